[rtl/md5_pkg.sv]
// Shared types, constants and round tables of the MD5 digest core.
package md5_pkg;

	// Chaining word start values
	localparam logic [31:0] INIT_A = 32'h67452301;
	localparam logic [31:0] INIT_B = 32'hefcdab89;
	localparam logic [31:0] INIT_C = 32'h98badcfe;
	localparam logic [31:0] INIT_D = 32'h10325476;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	// First byte of the length field in the last block
	localparam logic [5:0] LEN_POS = 6'd56;

	// Sequencer states
	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_PREP  = 5'b00010,
		S_ROUND = 5'b00100,
		S_FOLD  = 5'b01000,
		S_OUT   = 5'b10000
	} md5_state_t;

	// How a block's bytes are formed while it is compressed
	typedef enum logic [1:0] {
		PM_DATA     = 2'd0, // buffer as written
		PM_PAD_LEN  = 2'd1, // data, 0x80, zeros, bit length
		PM_PAD_ONLY = 2'd2, // data, 0x80, zeros
		PM_LEN_ONLY = 2'd3  // zeros, bit length
	} pad_mode_t;

	// Additive round constants
	function automatic logic [31:0] round_const(input logic [5:0] r);
		logic [31:0] k;
		case (r)
			6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
			6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
			6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
			6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
			6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
		endcase
		return k;
	endfunction

	// Message word index used in round r
	function automatic logic [3:0] msg_index(input logic [5:0] r);
		logic [3:0] g;
		case (r[5:4])
			2'd0: g = r[3:0];
			2'd1: g = 4'(r[3:0] * 4'd5 + 4'd1);
			2'd2: g = 4'(r[3:0] * 4'd3 + 4'd5);
			default: g = 4'(r[3:0] * 4'd7);
		endcase
		return g;
	endfunction

	// Left rotate amount of round r
	function automatic logic [4:0] rot_amount(input logic [5:0] r);
		logic [4:0] s;
		case ({r[5:4], r[1:0]})
			4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
			4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
			4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
			4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
		endcase
		return s;
	endfunction

endpackage

[rtl/md5_byte_if.sv]
// Input channel: one message byte and end mark per beat.
interface md5_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       byte_valid;
	logic       end_of_message;

	modport source (output valid, byte_value, byte_valid, end_of_message, input ready);
	modport sink (input valid, byte_value, byte_valid, end_of_message, output ready);
endinterface

[rtl/md5_digest_if.sv]
// Output channel: one digest word per beat.
interface md5_digest_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [1:0]  word_index;
	logic        last_word;

	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

[rtl/md5_message_digest_core.sv]
// MD5 digest core: byte collection, padding, round sequencer and digest output.
//
// The core takes one message byte per beat. A beat that does not fill a block
// and carries no end mark is taken without holding the input off. A beat that
// completes a 64-byte block holds the input off while the core loads the
// working words (S_PREP), runs the 64 MD5 rounds on the single round unit
// (S_ROUND) and adds the result into the chaining words (S_FOLD). An end mark
// runs padding as one such compression, or two when fewer than nine bytes of
// the last block are free, and the four digest words A, B, C, D then leave on
// the output channel one per beat, after which the core is ready for a new
// message. Padding bytes and the bit length are formed as the message words
// are read, so no clearing pass is needed.
module md5_message_digest_core
	import md5_pkg::*;
(
	input logic clk,
	input logic arst_n,
	md5_byte_if.sink in_ch,
	md5_digest_if.source out_ch
);

	md5_state_t  state_q;
	pad_mode_t   mode_q;
	logic        end_q;
	logic [5:0]  pos_q;
	logic [63:0] len_q;
	logic [5:0]  rnd_q;
	logic [1:0]  idx_q;
	logic [31:0] chain_q [4];
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [31:0] kw_q;
	logic [31:0] blk_q [16];

	logic        in_beat, out_beat;
	logic [5:0]  pos_nx;
	logic [5:0]  rnd_fetch;
	logic [3:0]  g_sel;
	logic [31:0] msg_word;
	logic [31:0] f_val, t_val, rot_val;
	logic [63:0] rot_dbl;

	assign in_beat  = in_ch.valid && in_ch.ready;
	assign out_beat = out_ch.valid && out_ch.ready;
	assign pos_nx   = in_ch.byte_valid ? pos_q + 6'd1 : pos_q;

	assign in_ch.ready        = (state_q == S_IDLE);
	assign out_ch.valid       = (state_q == S_OUT);
	assign out_ch.digest_word = chain_q[idx_q];
	assign out_ch.word_index  = idx_q;
	assign out_ch.last_word   = (idx_q == 2'd3);

	// Message word fetch for the coming round, with padding applied
	assign rnd_fetch = (state_q == S_ROUND) ? rnd_q + 6'd1 : rnd_q;
	assign g_sel     = msg_index(rnd_fetch);

	always_comb begin
		logic [5:0] p;
		logic [7:0] raw, lenb, bv;
		for (int j = 0; j < 4; j++) begin
			p    = {g_sel, 2'(j)};
			raw  = blk_q[g_sel][8*j +: 8];
			lenb = len_q[{p[2:0], 3'b000} +: 8];
			case (mode_q)
				PM_DATA:     bv = raw;
				PM_PAD_ONLY: bv = (p < pos_q) ? raw : (p == pos_q) ? PAD_BYTE : 8'h00;
				PM_LEN_ONLY: bv = (p < LEN_POS) ? 8'h00 : lenb;
				default:     bv = (p < pos_q) ? raw : (p == pos_q) ? PAD_BYTE :
					(p < LEN_POS) ? 8'h00 : lenb;
			endcase
			msg_word[8*j +: 8] = bv;
		end
	end

	// Shared round unit
	always_comb begin
		case (rnd_q[5:4])
			2'd0: f_val = (b_q & c_q) | (~b_q & d_q);
			2'd1: f_val = (d_q & b_q) | (~d_q & c_q);
			2'd2: f_val = b_q ^ c_q ^ d_q;
			default: f_val = c_q ^ (b_q | ~d_q);
		endcase
		t_val   = f_val + a_q + kw_q;
		rot_dbl = {t_val, t_val} << rot_amount(rnd_q);
		rot_val = rot_dbl[63:32];
	end

	// Block store: byte writes, no reset
	always_ff @(posedge clk) begin
		if (in_beat && in_ch.byte_valid) begin
			blk_q[pos_q[5:2]][{pos_q[1:0], 3'b000} +: 8] <= in_ch.byte_value;
		end
	end

	// Working words and prefetched constant plus message word
	always_ff @(posedge clk) begin
		if (state_q == S_PREP || state_q == S_ROUND) begin
			kw_q <= round_const(rnd_fetch) + msg_word;
		end
		if (state_q == S_PREP) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
		end else if (state_q == S_ROUND) begin
			a_q <= d_q;
			d_q <= c_q;
			c_q <= b_q;
			b_q <= b_q + rot_val;
		end
	end

	// Sequencer and message state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			mode_q     <= PM_DATA;
			end_q      <= 1'b0;
			pos_q      <= '0;
			len_q      <= '0;
			rnd_q      <= '0;
			idx_q      <= '0;
			chain_q[0] <= INIT_A;
			chain_q[1] <= INIT_B;
			chain_q[2] <= INIT_C;
			chain_q[3] <= INIT_D;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_beat) begin
						pos_q <= pos_nx;
						end_q <= in_ch.end_of_message;
						if (in_ch.byte_valid) begin
							len_q <= len_q + 64'd8;
						end
						if (in_ch.byte_valid && pos_q == 6'd63) begin
							mode_q  <= PM_DATA;
							state_q <= S_PREP;
						end else if (in_ch.end_of_message) begin
							mode_q  <= (pos_nx > 6'd55) ? PM_PAD_ONLY : PM_PAD_LEN;
							state_q <= S_PREP;
						end
					end
				end
				S_PREP: begin
					state_q <= S_ROUND;
				end
				S_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						state_q <= S_FOLD;
					end
				end
				S_FOLD: begin
					chain_q[0] <= chain_q[0] + a_q;
					chain_q[1] <= chain_q[1] + b_q;
					chain_q[2] <= chain_q[2] + c_q;
					chain_q[3] <= chain_q[3] + d_q;
					unique case (mode_q)
						PM_DATA: begin
							if (end_q) begin
								mode_q  <= (pos_q > 6'd55) ? PM_PAD_ONLY : PM_PAD_LEN;
								state_q <= S_PREP;
							end else begin
								state_q <= S_IDLE;
							end
						end
						PM_PAD_ONLY: begin
							mode_q  <= PM_LEN_ONLY;
							state_q <= S_PREP;
						end
						default: begin
							idx_q   <= '0;
							state_q <= S_OUT;
						end
					endcase
				end
				S_OUT: begin
					if (out_beat) begin
						idx_q <= idx_q + 2'd1;
						if (idx_q == 2'd3) begin
							chain_q[0] <= INIT_A;
							chain_q[1] <= INIT_B;
							chain_q[2] <= INIT_C;
							chain_q[3] <= INIT_D;
							len_q      <= '0;
							pos_q      <= '0;
							end_q      <= 1'b0;
							mode_q     <= PM_DATA;
							state_q    <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Input and output never open together
	a_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !out_ch.valid)
		else $error("input ready while digest is shown");

	// An end mark always starts a compression
	a_end_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_beat && in_ch.end_of_message) |=> state_q == S_PREP)
		else $error("end mark did not start padding");

	// The last round is followed by the fold
	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROUND && rnd_q == 6'd63) |=> state_q == S_FOLD)
		else $error("round count overran");

	// After the fourth word the message state is clear
	a_msg_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(out_beat && out_ch.last_word) |=>
			(in_ch.ready && pos_q == 6'd0 && len_q == 64'd0 && chain_q[0] == INIT_A))
		else $error("message state not cleared after digest");

endmodule

[tb/sv/md5_message_digest_core_tb.sv]
// Self-checking testbench of the MD5 digest core: byte stream in, digest words out.
`timescale 1ns / 100ps

module md5_message_digest_core_tb;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int BEAT_TARGET  = 420;
	localparam int SETTLE_TICKS = 300;

	// Chaining word start values
	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam int         LEN_FIELD_POS = 56;

	// Sine table, round 0 in the top word
	localparam logic [64*32-1:0] SINE_K = {
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	// Rotate amounts, four per round group, first entry in the top slot
	localparam logic [16*5-1:0] ROT_TAB = {
		5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
	};

	typedef struct packed {
		logic [31:0] word_val;
		logic [1:0]  word_pos;
		logic        is_last;
	} digest_beat_t;

	logic clk = 1'b0;
	logic arst_n;

	md5_byte_if   in_ch();
	md5_digest_if out_ch();

	md5_message_digest_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #5 clk = ~clk;

	// Predictor state
	logic [31:0] chain_state [4];
	logic [7:0]  block_bytes [64];
	logic [63:0] msg_bits;
	logic [5:0]  fill_pos;

	digest_beat_t expected_digests [$];
	int errors = 0;
	int beats_sent;
	int cycle_count = 0;
	bit steady;

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= 30)
			$display("ERROR @%0t: %s", $time, msg);
	endtask

	function automatic logic [31:0] rotl32(input logic [31:0] v, input int amt);
		return (v << amt) | (v >> (32 - amt));
	endfunction

	function automatic void restart_chain();
		chain_state[0] = IV_A;
		chain_state[1] = IV_B;
		chain_state[2] = IV_C;
		chain_state[3] = IV_D;
		msg_bits = '0;
		fill_pos = '0;
	endfunction

	// One 64-round compression of block_bytes into chain_state
	function automatic void md5_compress_block();
		logic [31:0] m [16];
		logic [31:0] a, b, c, d, f, t;
		int g;
		a = chain_state[0];
		b = chain_state[1];
		c = chain_state[2];
		d = chain_state[3];
		for (int w = 0; w < 16; w++)
			m[w] = {block_bytes[4*w+3], block_bytes[4*w+2],
				block_bytes[4*w+1], block_bytes[4*w]};
		for (int r = 0; r < 64; r++) begin
			case (r / 16)
				0: begin
					f = (b & c) | (~b & d);
					g = r;
				end
				1: begin
					f = (d & b) | (~d & c);
					g = (5*r + 1) % 16;
				end
				2: begin
					f = b ^ c ^ d;
					g = (3*r + 5) % 16;
				end
				default: begin
					f = c ^ (b | ~d);
					g = (7*r) % 16;
				end
			endcase
			t = f + a + SINE_K[32*(63-r) +: 32] + m[g];
			a = d;
			d = c;
			c = b;
			b = b + rotl32(t, int'(ROT_TAB[5*(15 - ((r/16)*4 + r%4)) +: 5]));
		end
		chain_state[0] += a;
		chain_state[1] += b;
		chain_state[2] += c;
		chain_state[3] += d;
	endfunction

	// Absorb one accepted beat; an end mark pads, finishes and queues four words
	function automatic void md5_absorb_beat(input logic [7:0] v, input logic bv,
			input logic eom);
		int p;
		digest_beat_t w;
		if (bv) begin
			block_bytes[fill_pos] = v;
			msg_bits += 64'd8;
			fill_pos = fill_pos + 6'd1;
			if (fill_pos == 6'd0)
				md5_compress_block();
		end
		if (!eom)
			return;
		p = int'(fill_pos);
		block_bytes[p] = PAD_MARK;
		p = p + 1;
		// No room left for the length: spill into a second block
		if (p > LEN_FIELD_POS) begin
			while (p < 64) begin
				block_bytes[p] = 8'h00;
				p = p + 1;
			end
			md5_compress_block();
			p = 0;
		end
		while (p < LEN_FIELD_POS) begin
			block_bytes[p] = 8'h00;
			p = p + 1;
		end
		for (int k = 0; k < 8; k++)
			block_bytes[LEN_FIELD_POS + k] = msg_bits[8*k +: 8];
		md5_compress_block();
		for (int k = 0; k < 4; k++) begin
			w.word_val = chain_state[k];
			w.word_pos = k[1:0];
			w.is_last  = (k == 3);
			expected_digests.push_back(w);
		end
		restart_chain();
	endfunction

	// Drive one beat, with random idle cycles ahead of it unless steady is set, and wait for acceptance
	task automatic send_beat(input logic [7:0] v, input logic bv, input logic eom);
		while (!steady && $urandom_range(99) < 32) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid          <= 1'b1;
		in_ch.byte_value     <= v;
		in_ch.byte_valid     <= bv;
		in_ch.end_of_message <= eom;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		md5_absorb_beat(v, bv, eom);
		if (bv || eom)
			beats_sent++;
	endtask

	// Random message body; the end rides on the last byte or comes alone
	task automatic send_message(input int len, input bit end_on_byte, input bit noisy);
		logic [7:0] v;
		for (int i = 0; i < len; i++) begin
			if (noisy && $urandom_range(99) < 10)
				send_beat(8'($urandom_range(255)), 1'b0, 1'b0);
			v = 8'($urandom_range(255));
			send_beat(v, 1'b1, end_on_byte && (i == len - 1));
		end
		if (len == 0 || !end_on_byte)
			send_beat(8'($urandom_range(255)), 1'b0, 1'b1);
	endtask

	task automatic drain_digests();
		in_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_digests.size() != 0);
	endtask

	// Empty message, noops, byte extremes, byte and end in one beat
	task automatic test_short_messages();
		send_beat(8'h00, 1'b0, 1'b1);
		send_beat(8'hff, 1'b0, 1'b0);
		send_beat(8'h61, 1'b1, 1'b0);
		send_beat(8'h62, 1'b1, 1'b0);
		send_beat(8'h63, 1'b1, 1'b1);
		send_beat(8'h00, 1'b1, 1'b0);
		send_beat(8'h00, 1'b0, 1'b0);
		send_beat(8'hff, 1'b1, 1'b0);
		send_beat(8'h5a, 1'b0, 1'b1);
		send_beat(8'hff, 1'b1, 1'b1);
		send_beat(8'h00, 1'b1, 1'b1);
		send_beat(8'ha5, 1'b0, 1'b1);
	endtask

	// Lengths around the pad split and a full block, back to back with no idling
	task automatic test_block_boundaries();
		steady = 1'b1;
		send_message(55, 1'b1, 1'b0);
		send_message(56, 1'b1, 1'b0);
		send_message(64, 1'b0, 1'b0);
		steady = 1'b0;
	endtask

	// Sender holds off until every digest word of the last message is out
	task automatic test_drain_between_messages();
		for (int i = 0; i < 4; i++) begin
			send_message($urandom_range(1, 20), 1'($urandom_range(1)), 1'b1);
			drain_digests();
		end
	endtask

	// Mostly short messages, some multi-block ones, noops mixed in
	task automatic test_random_messages();
		int msg_count;
		int len;
		int pick;
		msg_count = 0;
		while (beats_sent < BEAT_TARGET || msg_count < 16) begin
			pick = $urandom_range(99);
			if (pick < 80)
				len = $urandom_range(0, 24);
			else if (pick < 95)
				len = $urandom_range(25, 70);
			else
				len = $urandom_range(64, 130);
			send_message(len, 1'($urandom_range(1)), 1'b1);
			msg_count++;
		end
	endtask

	// Result side: random backpressure, check every accepted word in order
	always @(posedge clk) begin
		digest_beat_t exp_w;
		out_ch.ready <= steady || ($urandom_range(99) >= 32);
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_digests.size() == 0) begin
				report_mismatch($sformatf("unexpected digest word %h", out_ch.digest_word));
			end else begin
				exp_w = expected_digests.pop_front();
				if (out_ch.digest_word !== exp_w.word_val)
					report_mismatch($sformatf("digest_word %h, want %h",
						out_ch.digest_word, exp_w.word_val));
				if (out_ch.word_index !== exp_w.word_pos)
					report_mismatch($sformatf("word_index %0d, want %0d",
						out_ch.word_index, exp_w.word_pos));
				if (out_ch.last_word !== exp_w.is_last)
					report_mismatch($sformatf("last_word %b, want %b",
						out_ch.last_word, exp_w.is_last));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("md5_message_digest_core: mismatch");
			$finish;
		end
	end

	initial begin
		beats_sent  = 0;
		steady      = 1'b0;
		restart_chain();
		arst_n               <= 1'b0;
		in_ch.valid          <= 1'b0;
		in_ch.byte_value     <= 8'h00;
		in_ch.byte_valid     <= 1'b0;
		in_ch.end_of_message <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_short_messages();
		test_block_boundaries();
		test_drain_between_messages();
		test_random_messages();

		drain_digests();
		repeat (SETTLE_TICKS) @(posedge clk);
		if (errors == 0)
			$display("md5_message_digest_core: match");
		else
			$display("md5_message_digest_core: mismatch");
		$finish;
	end

endmodule
